// ===== rtl/mtep_pkg.sv =====
// Shared types, codes and widths of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

  // Longest variable-length quantity, in bytes
  localparam int VLQ_MAX_BYTES = 4;
  localparam int ACC_W = 7 * VLQ_MAX_BYTES;
  localparam int CNT_W = $clog2(VLQ_MAX_BYTES + 1);
  localparam int TICK_W = 32;
  localparam int SUM_W = (ACC_W > TICK_W) ? ACC_W : TICK_W;

  localparam int TDATA_W = 104;

  // Status bytes and meta types
  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_PORT = 8'h21;

  // Upper status nibbles
  localparam logic [3:0] MSG_PROGRAM = 4'hC;
  localparam logic [3:0] MSG_PRESSURE = 4'hD;
  localparam logic [3:0] MSG_BEND = 4'hE;
  localparam logic [3:0] MSG_SYSTEM = 4'hF;

  typedef enum logic [8:0] {
    PH_DELTA      = 9'b000000001,
    PH_STATUS     = 9'b000000010,
    PH_META_TYPE  = 9'b000000100,
    PH_META_LEN   = 9'b000001000,
    PH_META_DATA  = 9'b000010000,
    PH_SYSEX_LEN  = 9'b000100000,
    PH_SYSEX_DATA = 9'b001000000,
    PH_PARAM1     = 9'b010000000,
    PH_PARAM2     = 9'b100000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_VLQ    = 2'd0,
    ERR_NO_RUNNING = 2'd1,
    ERR_TRUNCATED  = 2'd2
  } err_t;

  typedef struct packed {
    logic       track_start;
    logic       track_end;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [TICK_W-1:0]   tick;
    logic [3:0]          msg_type;
    logic [11:0]         channel;
    logic [6:0]          key;
    logic [6:0]          velocity;
    logic [13:0]         bend_value;
    logic [23:0]         tempo;
    err_t                error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mtep_in_stage.sv =====
// Input register that holds one track byte until the parser takes it.
`default_nettype none

module mtep_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire mtep_pkg::item_t s_item,
  input  wire logic            advance,
  output logic                 valid,
  output mtep_pkg::item_t      item
);
  import mtep_pkg::*;

  // Take a new item when empty or when the held one moves on
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtep_core.sv =====
// Parser state and the per-byte decode of delta times, statuses and events.
`default_nettype none

module mtep_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire mtep_pkg::item_t item,
  output logic                 res_valid,
  output mtep_pkg::result_t    res
);
  import mtep_pkg::*;

  phase_t             phase, phase_cur, phase_next;
  logic [ACC_W-1:0]   vlq_accum, vlq_accum_cur, vlq_accum_next;
  logic [CNT_W-1:0]   vlq_count, vlq_count_cur, vlq_count_next;
  logic [TICK_W-1:0]  tick_count, tick_count_cur, tick_count_next;
  logic [7:0]         running_status, running_status_cur, running_status_next;
  logic [7:0]         current_status, current_status_cur, current_status_next;
  logic [7:0]         port_number, port_number_cur, port_number_next;
  logic [7:0]         meta_kind, meta_kind_cur, meta_kind_next;
  logic [ACC_W-1:0]   bytes_left, bytes_left_cur, bytes_left_next;
  logic [6:0]         first_param, first_param_cur, first_param_next;
  logic [23:0]        tempo_accum, tempo_accum_cur, tempo_accum_next;
  logic               halted, halted_cur, halted_next;

  logic [7:0]         b;
  logic [ACC_W-1:0]   acc_shift;
  logic [CNT_W-1:0]   cnt_inc;
  logic               vlq_long;
  logic [SUM_W-1:0]   tick_sum;
  logic [ACC_W-1:0]   left_dec;
  logic               take_p1;
  logic [3:0]         p1_type;
  logic               emit_ch;
  logic [6:0]         ch_p1;
  logic [6:0]         ch_p2;
  logic               emit_tempo;
  logic               emit_err;
  err_t               err_code;

  // Track start clears the parser before its byte is decoded
  always_comb begin
    if (item.track_start) begin
      phase_cur          = PH_DELTA;
      vlq_accum_cur      = '0;
      vlq_count_cur      = '0;
      tick_count_cur     = '0;
      running_status_cur = '0;
      current_status_cur = '0;
      port_number_cur    = '0;
      meta_kind_cur      = '0;
      bytes_left_cur     = '0;
      first_param_cur    = '0;
      tempo_accum_cur    = '0;
      halted_cur         = 1'b0;
    end else begin
      phase_cur          = phase;
      vlq_accum_cur      = vlq_accum;
      vlq_count_cur      = vlq_count;
      tick_count_cur     = tick_count;
      running_status_cur = running_status;
      current_status_cur = current_status;
      port_number_cur    = port_number;
      meta_kind_cur      = meta_kind;
      bytes_left_cur     = bytes_left;
      first_param_cur    = first_param;
      tempo_accum_cur    = tempo_accum;
      halted_cur         = halted;
    end
  end

  // Shared VLQ step and counters
  assign b         = item.data_byte;
  assign acc_shift = ACC_W'({vlq_accum_cur, b[6:0]});
  assign cnt_inc   = vlq_count_cur + CNT_W'(1);
  assign vlq_long  = b[7] && (cnt_inc >= CNT_W'(VLQ_MAX_BYTES));
  assign tick_sum  = SUM_W'(tick_count_cur) + SUM_W'(acc_shift);
  assign left_dec  = bytes_left_cur - ACC_W'(1);

  // Decode one byte
  always_comb begin
    phase_next          = phase_cur;
    vlq_accum_next      = vlq_accum_cur;
    vlq_count_next      = vlq_count_cur;
    tick_count_next     = tick_count_cur;
    running_status_next = running_status_cur;
    current_status_next = current_status_cur;
    port_number_next    = port_number_cur;
    meta_kind_next      = meta_kind_cur;
    bytes_left_next     = bytes_left_cur;
    first_param_next    = first_param_cur;
    tempo_accum_next    = tempo_accum_cur;
    halted_next         = halted_cur;
    take_p1             = 1'b0;
    emit_ch             = 1'b0;
    ch_p1               = '0;
    ch_p2               = '0;
    emit_tempo          = 1'b0;
    emit_err            = 1'b0;
    err_code            = ERR_BAD_VLQ;
    p1_type             = '0;
    res_valid           = 1'b0;
    res                 = '0;

    if (!halted_cur) begin
      unique case (phase_cur)
        PH_DELTA: begin
          if (vlq_long) begin
            emit_err = 1'b1;
            err_code = ERR_BAD_VLQ;
          end else if (b[7]) begin
            vlq_accum_next = acc_shift;
            vlq_count_next = cnt_inc;
          end else begin
            tick_count_next = tick_sum[TICK_W-1:0];
            vlq_accum_next  = '0;
            vlq_count_next  = '0;
            phase_next      = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (!running_status_cur[7]) begin
              emit_err = 1'b1;
              err_code = ERR_NO_RUNNING;
            end else begin
              current_status_next = running_status_cur;
              take_p1 = 1'b1;
            end
          end else begin
            current_status_next = b;
            if (b == STATUS_META) begin
              running_status_next = '0;
              phase_next = PH_META_TYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_SYSEX_ESC) begin
              running_status_next = '0;
              vlq_accum_next = '0;
              vlq_count_next = '0;
              phase_next = PH_SYSEX_LEN;
            end else if (b[7:4] == MSG_SYSTEM) begin
              running_status_next = '0;
              phase_next = PH_PARAM1;
            end else begin
              running_status_next = b;
              phase_next = PH_PARAM1;
            end
          end
        end
        PH_META_TYPE: begin
          meta_kind_next = b;
          vlq_accum_next = '0;
          vlq_count_next = '0;
          phase_next     = PH_META_LEN;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          if (vlq_long) begin
            emit_err = 1'b1;
            err_code = ERR_BAD_VLQ;
          end else if (b[7]) begin
            vlq_accum_next = acc_shift;
            vlq_count_next = cnt_inc;
          end else begin
            bytes_left_next  = acc_shift;
            vlq_accum_next   = '0;
            vlq_count_next   = '0;
            tempo_accum_next = '0;
            if (phase_cur == PH_META_LEN) begin
              // Keep only tempo and port metas whose length fits
              if ((meta_kind_cur == META_TEMPO && acc_shift != ACC_W'(3)) ||
                  (meta_kind_cur == META_PORT && acc_shift != ACC_W'(1))) begin
                meta_kind_next = '0;
              end
              phase_next = PH_META_DATA;
            end else begin
              phase_next = PH_SYSEX_DATA;
            end
            if (acc_shift == '0) begin
              phase_next = PH_DELTA;
            end
          end
        end
        PH_META_DATA: begin
          tempo_accum_next = {tempo_accum_cur[15:0], b};
          if (meta_kind_cur == META_PORT) begin
            port_number_next = b;
          end
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_DELTA;
            emit_tempo = (meta_kind_cur == META_TEMPO);
          end
        end
        PH_SYSEX_DATA: begin
          bytes_left_next = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_DELTA;
          end
        end
        PH_PARAM1: begin
          take_p1 = 1'b1;
        end
        PH_PARAM2: begin
          emit_ch = 1'b1;
          ch_p1   = first_param_cur;
          ch_p2   = b[6:0];
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase

      // First data byte: one-byte messages emit, two-byte ones wait, system ones end
      if (take_p1) begin
        p1_type = current_status_next[7:4];
        if (p1_type == MSG_PROGRAM || p1_type == MSG_PRESSURE) begin
          emit_ch = 1'b1;
          ch_p1   = b[6:0];
        end else if (p1_type[3] && p1_type != MSG_SYSTEM) begin
          first_param_next = b[6:0];
          phase_next = PH_PARAM2;
        end else begin
          phase_next = PH_DELTA;
        end
      end

      if (emit_ch) begin
        phase_next = PH_DELTA;
      end
      if (emit_err) begin
        halted_next = 1'b1;
      end

      // Track end inside an unfinished event is a truncation
      if (item.track_end && !halted_next) begin
        if (phase_next != PH_DELTA || vlq_count_next != '0) begin
          emit_err = 1'b1;
          err_code = ERR_TRUNCATED;
        end
        halted_next = 1'b1;
      end

      // Build the result
      res.tick = tick_count_next;
      if (emit_err) begin
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = err_code;
      end else if (emit_tempo) begin
        res_valid = 1'b1;
        res.kind  = KIND_TEMPO;
        res.tempo = tempo_accum_next;
      end else if (emit_ch) begin
        res_valid    = 1'b1;
        res.kind     = KIND_CHANNEL;
        res.msg_type = current_status_next[7:4];
        res.channel  = {port_number_cur, current_status_next[3:0]};
        res.key      = ch_p1;
        if (current_status_next[7:4] == MSG_BEND) begin
          res.bend_value = {ch_p2, ch_p1};
        end else if (current_status_next[7:4] != MSG_PROGRAM &&
                     current_status_next[7:4] != MSG_PRESSURE) begin
          res.velocity = ch_p2;
        end
      end
    end
  end

  // Commit the state for each taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      vlq_accum      <= '0;
      vlq_count      <= '0;
      tick_count     <= '0;
      running_status <= '0;
      current_status <= '0;
      port_number    <= '0;
      meta_kind      <= '0;
      bytes_left     <= '0;
      first_param    <= '0;
      tempo_accum    <= '0;
      halted         <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      vlq_accum      <= vlq_accum_next;
      vlq_count      <= vlq_count_next;
      tick_count     <= tick_count_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      port_number    <= port_number_next;
      meta_kind      <= meta_kind_next;
      bytes_left     <= bytes_left_next;
      first_param    <= first_param_next;
      tempo_accum    <= tempo_accum_next;
      halted         <= halted_next;
    end
  end

  // An error stops the track until the next start
  assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == KIND_ERROR |=> halted)
    else $error("error item did not halt the parser");

  // A halted track gives nothing until restarted
  assert property (@(posedge clk) disable iff (rst)
    halted && !item.track_start |-> !res_valid)
    else $error("result from a halted track");

  // Channel events carry a channel message type
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_CHANNEL |-> res.msg_type[3] && res.msg_type != MSG_SYSTEM)
    else $error("channel event with a non-channel status");

  // Ticks only move forward at a delta time byte
  assert property (@(posedge clk) disable iff (rst)
    take && phase_cur != PH_DELTA |=> tick_count == $past(tick_count_cur))
    else $error("tick changed outside a delta time");

endmodule

`default_nettype wire

// ===== rtl/mtep_out_stage.sv =====
// Result register that holds one event until the consumer takes it.
`default_nettype none

module mtep_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire mtep_pkg::result_t res,
  output logic                   free,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output mtep_pkg::result_t      m_res
);
  import mtep_pkg::*;

  // Room for a new result when empty or being drained
  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      m_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: input register, decoder, result register.
//
//  channel  dir  tdata                     tuser          tlast
//  s_       in   data_byte[7:0]            track_start    track_end
//  m_       out  event fields (see port)   kind[1:0]      -
//
// One byte per cycle when the result side is ready; a taken byte is held in the input
// register, decoded there, and its event is registered in the result register.
// Decoding is a single combinational step between the two registers.
// Reset (rst, synchronous) empties both registers and clears the parser state.
// A stalled result holds the decoder; the input register then fills and drops s_tready.
`default_nettype none

module midi_track_event_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // s_tdata: data_byte[7:0]
  input  wire logic [7:0]                     s_tdata,
  // s_tuser: track_start
  input  wire logic                           s_tuser,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // m_tdata: tick[31:0], msg_type[35:32], channel[47:36], key[54:48],
  //          velocity[61:55], bend_value[75:62], tempo[99:76],
  //          error_code[101:100], zero pad[103:102]
  output logic [mtep_pkg::TDATA_W-1:0]        m_tdata,
  // m_tuser: kind[1:0]
  output logic [1:0]                          m_tuser
);
  import mtep_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item.data_byte   = s_tdata;
  assign s_item.track_start = s_tuser;
  assign s_item.track_end   = s_tlast;

  // Decode the held byte when the result register has room
  assign advance = item_valid && out_free;

  mtep_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .advance  (advance),
    .valid    (item_valid),
    .item     (item)
  );

  mtep_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mtep_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  // Pack the result fields, highest first
  assign m_tdata = {2'b00, m_res.error_code, m_res.tempo, m_res.bend_value,
                    m_res.velocity, m_res.key, m_res.channel, m_res.msg_type,
                    m_res.tick};
  assign m_tuser = m_res.kind;

endmodule

`default_nettype wire
